### rtl/ebml_pkg.sv
package ebml_pkg;

  localparam int NODE_CAPACITY_DEF = 512;

  localparam int ACTION_W   = 2;
  localparam int MAGIC_W    = 16;
  localparam int ENTRIES_W  = 10;
  localparam int DEPTH_W    = 16;
  localparam int BLOCK_W    = 32;
  localparam int LENGTH_W   = 16;
  localparam int ADDR_HI_W  = 16;
  localparam int LEN_KEEP_W = 15;
  localparam int STATUS_W   = 3;

  localparam logic [MAGIC_W-1:0] EXTENT_MAGIC = 16'hF30A;

  typedef enum logic [ACTION_W-1:0] {
    ACT_LOAD_HDR   = 2'd0,
    ACT_LOAD_ENTRY = 2'd1,
    ACT_LOOKUP     = 2'd2
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_FOUND     = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_BAD_MAGIC = 3'd2,
    ST_BAD_DEPTH = 3'd3,
    ST_ADDR_HIGH = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [BLOCK_W-1:0]    first;
    logic [LEN_KEEP_W-1:0] len;
    logic                  high_nz;
    logic [BLOCK_W-1:0]    addr;
  } entry_t;

  typedef struct packed {
    logic hdr_we;
    logic ent_we;
    logic lkp_start;
    logic scan_adv;
    logic res_pre;
    logic res_scan;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    action_t act;
    logic    pre_done;
    logic    stop;
    logic    out_free;
  } dp_stat_t;

endpackage

### rtl/ebml_in_if.sv
interface ebml_in_if;
  logic                               valid;
  logic                               ready;
  logic [ebml_pkg::ACTION_W-1:0]      action;
  logic [ebml_pkg::MAGIC_W-1:0]       node_magic;
  logic [ebml_pkg::ENTRIES_W-1:0]     node_entries;
  logic [ebml_pkg::DEPTH_W-1:0]       node_depth;
  logic [ebml_pkg::BLOCK_W-1:0]       entry_first_block;
  logic [ebml_pkg::LENGTH_W-1:0]      entry_length;
  logic [ebml_pkg::ADDR_HI_W-1:0]     entry_addr_high;
  logic [ebml_pkg::BLOCK_W-1:0]       entry_addr_low;
  logic [ebml_pkg::BLOCK_W-1:0]       logical_block;

  modport source (
    output valid, action, node_magic, node_entries, node_depth, entry_first_block,
           entry_length, entry_addr_high, entry_addr_low, logical_block,
    input  ready
  );
  modport sink (
    input  valid, action, node_magic, node_entries, node_depth, entry_first_block,
           entry_length, entry_addr_high, entry_addr_low, logical_block,
    output ready
  );
endinterface

### rtl/ebml_out_if.sv
interface ebml_out_if;
  logic                          valid;
  logic                          ready;
  logic [ebml_pkg::STATUS_W-1:0] status;
  logic [ebml_pkg::BLOCK_W-1:0]  physical_block;
  logic                          points_to_leaf;

  modport source (
    output valid, status, physical_block, points_to_leaf,
    input  ready
  );
  modport sink (
    input  valid, status, physical_block, points_to_leaf,
    output ready
  );
endinterface

### rtl/ebml_ram.sv
module ebml_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/ebml_ctrl.sv
module ebml_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  ebml_pkg::dp_stat_t stat,
  output ebml_pkg::dp_cmd_t  cmd
);

  ebml_pkg::state_t state_r;
  ebml_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ebml_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ebml_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (stat.act)
            ebml_pkg::ACT_LOAD_HDR: begin
              cmd.hdr_we = 1'b1;
            end
            ebml_pkg::ACT_LOAD_ENTRY: begin
              cmd.ent_we = 1'b1;
            end
            ebml_pkg::ACT_LOOKUP: begin
              cmd.lkp_start = 1'b1;
              if (stat.pre_done) begin
                cmd.res_pre = 1'b1;
                state_nxt   = ebml_pkg::S_DONE;
              end else begin
                state_nxt = ebml_pkg::S_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ebml_pkg::S_SCAN: begin
        if (stat.stop) begin
          cmd.res_scan = 1'b1;
          state_nxt    = ebml_pkg::S_DONE;
        end else begin
          cmd.scan_adv = 1'b1;
        end
      end
      ebml_pkg::S_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ebml_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = ebml_pkg::S_IDLE;
      end
    endcase
  end

endmodule

### rtl/ebml_dp.sv
module ebml_dp #(
  parameter int NODE_CAPACITY = ebml_pkg::NODE_CAPACITY_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  ebml_pkg::dp_cmd_t              cmd,
  output ebml_pkg::dp_stat_t             stat,
  input  logic [ebml_pkg::ACTION_W-1:0]  in_action,
  input  logic [ebml_pkg::MAGIC_W-1:0]   in_node_magic,
  input  logic [ebml_pkg::ENTRIES_W-1:0] in_node_entries,
  input  logic [ebml_pkg::DEPTH_W-1:0]   in_node_depth,
  input  logic [ebml_pkg::BLOCK_W-1:0]   in_entry_first_block,
  input  logic [ebml_pkg::LENGTH_W-1:0]  in_entry_length,
  input  logic [ebml_pkg::ADDR_HI_W-1:0] in_entry_addr_high,
  input  logic [ebml_pkg::BLOCK_W-1:0]   in_entry_addr_low,
  input  logic [ebml_pkg::BLOCK_W-1:0]   in_logical_block,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [ebml_pkg::STATUS_W-1:0]  out_status,
  output logic [ebml_pkg::BLOCK_W-1:0]   out_physical_block,
  output logic                           out_points_to_leaf
);

  localparam int AW    = $clog2(NODE_CAPACITY);
  localparam int CNT_W = $clog2(NODE_CAPACITY + 1);
  localparam int BW    = ebml_pkg::BLOCK_W;

  logic                          magic_ok_r;
  logic [ebml_pkg::DEPTH_W-1:0]  depth_r;
  logic [CNT_W-1:0]              count_r;
  logic [CNT_W-1:0]              wslot_r;
  logic [BW-1:0]                 lb_r;
  logic [AW-1:0]                 cur_r;
  logic                          have_r;
  logic                          pick_high_r;
  logic [BW-1:0]                 pick_addr_r;
  ebml_pkg::status_t             res_status_r;
  logic [BW-1:0]                 res_phys_r;
  logic                          res_leaf_r;
  logic                          out_valid_r;
  ebml_pkg::status_t             out_status_r;
  logic [BW-1:0]                 out_phys_r;
  logic                          out_leaf_r;

  logic [CNT_W-1:0]              hdr_count;
  logic                          tbl_we;
  logic [AW-1:0]                 rd_addr;
  ebml_pkg::entry_t              wr_ent;
  ebml_pkg::entry_t              ent;
  logic                          is_leaf;
  logic                          last;
  logic [BW:0]                   ext_end;
  logic                          hit;
  logic                          le;
  logic                          sel_have;
  logic                          sel_high;
  logic [BW-1:0]                 sel_addr;
  ebml_pkg::status_t             pre_status;
  ebml_pkg::status_t             res_status_nxt;
  logic [BW-1:0]                 res_phys_nxt;
  logic                          res_leaf_nxt;

  always_comb begin
    if (int'(in_node_entries) > NODE_CAPACITY) begin
      hdr_count = CNT_W'(NODE_CAPACITY);
    end else begin
      hdr_count = CNT_W'(in_node_entries);
    end
  end

  assign tbl_we         = cmd.ent_we && (wslot_r < CNT_W'(NODE_CAPACITY));
  assign wr_ent.first   = in_entry_first_block;
  assign wr_ent.len     = in_entry_length[ebml_pkg::LEN_KEEP_W-1:0];
  assign wr_ent.high_nz = (in_entry_addr_high != '0);
  assign wr_ent.addr    = in_entry_addr_low;
  assign rd_addr        = cmd.lkp_start ? '0 : cur_r + AW'(1);

  ebml_ram #(
    .WIDTH ($bits(ebml_pkg::entry_t)),
    .DEPTH (NODE_CAPACITY)
  ) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (wslot_r[AW-1:0]),
    .wdata (wr_ent),
    .raddr (rd_addr),
    .rdata (ent)
  );

  // one table entry examined per cycle
  assign is_leaf = (depth_r == '0);
  assign last    = (CNT_W'(cur_r) + CNT_W'(1)) == count_r;
  assign ext_end = {1'b0, ent.first} + (BW + 1)'(ent.len);
  assign hit     = (lb_r >= ent.first) && ({1'b0, lb_r} < ext_end);
  assign le      = (ent.first <= lb_r);

  always_comb begin
    if (le) begin
      sel_have = 1'b1;
      sel_high = ent.high_nz;
      sel_addr = ent.addr;
    end else begin
      sel_have = have_r;
      sel_high = pick_high_r;
      sel_addr = pick_addr_r;
    end
  end

  always_comb begin
    if (!magic_ok_r) begin
      pre_status = ebml_pkg::ST_BAD_MAGIC;
    end else if (depth_r > ebml_pkg::DEPTH_W'(1)) begin
      pre_status = ebml_pkg::ST_BAD_DEPTH;
    end else begin
      pre_status = ebml_pkg::ST_NOT_FOUND;
    end
  end

  always_comb begin
    res_status_nxt = ebml_pkg::ST_NOT_FOUND;
    res_phys_nxt   = '0;
    res_leaf_nxt   = 1'b0;
    if (is_leaf) begin
      if (hit) begin
        if (ent.high_nz) begin
          res_status_nxt = ebml_pkg::ST_ADDR_HIGH;
        end else begin
          res_status_nxt = ebml_pkg::ST_FOUND;
          res_phys_nxt   = ent.addr + (lb_r - ent.first);
        end
      end
    end else if (sel_have) begin
      if (sel_high) begin
        res_status_nxt = ebml_pkg::ST_ADDR_HIGH;
      end else begin
        res_status_nxt = ebml_pkg::ST_FOUND;
        res_phys_nxt   = sel_addr;
        res_leaf_nxt   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_ok_r  <= 1'b0;
      depth_r     <= '0;
      count_r     <= '0;
      wslot_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.hdr_we) begin
        magic_ok_r <= (in_node_magic == ebml_pkg::EXTENT_MAGIC);
        depth_r    <= in_node_depth;
        count_r    <= hdr_count;
        wslot_r    <= '0;
      end
      if (tbl_we) begin
        wslot_r <= wslot_r + CNT_W'(1);
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.lkp_start) begin
      lb_r   <= in_logical_block;
      cur_r  <= '0;
      have_r <= 1'b0;
    end
    if (cmd.scan_adv) begin
      cur_r <= cur_r + AW'(1);
      if (le) begin
        have_r      <= 1'b1;
        pick_high_r <= ent.high_nz;
        pick_addr_r <= ent.addr;
      end
    end
    if (cmd.res_pre) begin
      res_status_r <= pre_status;
      res_phys_r   <= '0;
      res_leaf_r   <= 1'b0;
    end
    if (cmd.res_scan) begin
      res_status_r <= res_status_nxt;
      res_phys_r   <= res_phys_nxt;
      res_leaf_r   <= res_leaf_nxt;
    end
    if (cmd.out_load) begin
      out_status_r <= res_status_r;
      out_phys_r   <= res_phys_r;
      out_leaf_r   <= res_leaf_r;
    end
  end

  assign stat.act      = ebml_pkg::action_t'(in_action);
  assign stat.pre_done = !magic_ok_r || (depth_r > ebml_pkg::DEPTH_W'(1)) || (count_r == '0);
  assign stat.stop     = last || (is_leaf ? hit : !le);
  assign stat.out_free = !out_valid_r || out_ready;

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_physical_block = out_phys_r;
  assign out_points_to_leaf = out_leaf_r;

endmodule

### rtl/extent_block_map_lookup.sv
// Extent-tree node lookup. Header transfers (action 0) and entry transfers
// (action 1) load the node; entries beyond the node capacity are dropped. A
// lookup transfer (action 2) scans the stored entries one per cycle through
// the node table memory; a bad magic, an unsupported depth or an empty node
// answer without a scan. A finished result sits in an output register, and
// header and entry transfers are still taken while it waits for the sink.
module extent_block_map_lookup #(
  parameter int NODE_CAPACITY = ebml_pkg::NODE_CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  ebml_in_if.sink     in_ch,
  ebml_out_if.source  out_ch
);

  ebml_pkg::dp_cmd_t  cmd;
  ebml_pkg::dp_stat_t stat;

  ebml_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ebml_dp #(
    .NODE_CAPACITY (NODE_CAPACITY)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .stat                 (stat),
    .in_action            (in_ch.action),
    .in_node_magic        (in_ch.node_magic),
    .in_node_entries      (in_ch.node_entries),
    .in_node_depth        (in_ch.node_depth),
    .in_entry_first_block (in_ch.entry_first_block),
    .in_entry_length      (in_ch.entry_length),
    .in_entry_addr_high   (in_ch.entry_addr_high),
    .in_entry_addr_low    (in_ch.entry_addr_low),
    .in_logical_block     (in_ch.logical_block),
    .out_valid            (out_ch.valid),
    .out_ready            (out_ch.ready),
    .out_status           (out_ch.status),
    .out_physical_block   (out_ch.physical_block),
    .out_points_to_leaf   (out_ch.points_to_leaf)
  );

endmodule

### rtl/ebml_checker.sv
module ebml_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [ebml_pkg::STATUS_W-1:0] out_status,
  input logic [ebml_pkg::BLOCK_W-1:0]  out_physical_block,
  input logic                          out_points_to_leaf
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
      && $stable(out_physical_block) && $stable(out_points_to_leaf))
    else $error("result changed while stalled");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ebml_pkg::ST_FOUND)
      |-> (out_physical_block == '0) && !out_points_to_leaf)
    else $error("non-found result carries a block number");

  a_leaf_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_points_to_leaf |-> (out_status == ebml_pkg::ST_FOUND))
    else $error("leaf pointer without found status");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind extent_block_map_lookup ebml_checker u_ebml_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .out_status         (out_ch.status),
  .out_physical_block (out_ch.physical_block),
  .out_points_to_leaf (out_ch.points_to_leaf)
);

### dv/extent_lookup_checker.sv
module extent_lookup_checker
  import ebml_pkg::*;
#(
  parameter int NODE_CAPACITY = NODE_CAPACITY_DEF
) (
  input  logic clk,
  input  logic rst_n,
  ebml_in_if   in_mon,
  ebml_out_if  out_mon,
  output int   fail_count,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    status_t            status;
    logic [BLOCK_W-1:0] physical_block;
    logic               points_to_leaf;
  } translation_t;

  translation_t expected_translations[$];

  logic                   magic_ok;
  logic [DEPTH_W-1:0]     node_depth;
  logic [ENTRIES_W-1:0]   entry_count;
  logic [ENTRIES_W-1:0]   write_ptr;
  logic [BLOCK_W-1:0]     first_tbl [NODE_CAPACITY];
  logic [LEN_KEEP_W-1:0]  len_tbl [NODE_CAPACITY];
  logic                   addr_hi_tbl [NODE_CAPACITY];
  logic [BLOCK_W-1:0]     addr_tbl [NODE_CAPACITY];
  int                     mismatches = 0;

  function automatic translation_t predict_translation(input logic [BLOCK_W-1:0] lb);
    translation_t r;
    logic [BLOCK_W:0] ext_end;
    bit hit;
    int pick;
    int i;
    r.status = ST_NOT_FOUND;
    r.physical_block = '0;
    r.points_to_leaf = 1'b0;
    hit = 1'b0;
    pick = 0;
    if (!magic_ok) begin
      r.status = ST_BAD_MAGIC;
    end else if (node_depth == '0) begin
      for (i = 0; i < int'(entry_count); i++) begin
        ext_end = {1'b0, first_tbl[i]} + {{(BLOCK_W + 1 - LEN_KEEP_W){1'b0}}, len_tbl[i]};
        if (lb >= first_tbl[i] && {1'b0, lb} < ext_end) begin
          if (addr_hi_tbl[i]) begin
            r.status = ST_ADDR_HIGH;
          end else begin
            r.status = ST_FOUND;
            r.physical_block = addr_tbl[i] + (lb - first_tbl[i]);
          end
          break;
        end
      end
    end else if (node_depth == DEPTH_W'(1)) begin
      for (i = 0; i < int'(entry_count); i++) begin
        if (first_tbl[i] <= lb) begin
          hit = 1'b1;
          pick = i;
        end else begin
          break;
        end
      end
      if (hit && addr_hi_tbl[pick]) begin
        r.status = ST_ADDR_HIGH;
      end else if (hit) begin
        r.status = ST_FOUND;
        r.physical_block = addr_tbl[pick];
        r.points_to_leaf = 1'b1;
      end
    end else begin
      r.status = ST_BAD_DEPTH;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    translation_t want;
    if (!rst_n) begin
      magic_ok = 1'b0;
      node_depth = '0;
      entry_count = '0;
      write_ptr = '0;
      expected_translations.delete();
    end else begin
      // results first, so a lookup taken on this edge cannot hide a stray result
      if (out_mon.valid && out_mon.ready) begin
        if (expected_translations.size() == 0) begin
          $display("%0t: unexpected result, actual status %0d block %h leaf %0d",
                   $time, out_mon.status, out_mon.physical_block, out_mon.points_to_leaf);
          mismatches++;
        end else begin
          want = expected_translations.pop_front();
          if (out_mon.status !== want.status) begin
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, want.status, out_mon.status);
            mismatches++;
          end
          if (out_mon.physical_block !== want.physical_block) begin
            $display("%0t: physical_block mismatch, expected %h, actual %h",
                     $time, want.physical_block, out_mon.physical_block);
            mismatches++;
          end
          if (out_mon.points_to_leaf !== want.points_to_leaf) begin
            $display("%0t: points_to_leaf mismatch, expected %0d, actual %0d",
                     $time, want.points_to_leaf, out_mon.points_to_leaf);
            mismatches++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        case (in_mon.action)
          ACT_LOAD_HDR: begin
            magic_ok = (in_mon.node_magic == EXTENT_MAGIC);
            node_depth = in_mon.node_depth;
            entry_count = (int'(in_mon.node_entries) > NODE_CAPACITY) ?
                          ENTRIES_W'(NODE_CAPACITY) : in_mon.node_entries;
            write_ptr = '0;
          end
          ACT_LOAD_ENTRY: begin
            if (int'(write_ptr) < NODE_CAPACITY) begin
              first_tbl[write_ptr] = in_mon.entry_first_block;
              len_tbl[write_ptr] = in_mon.entry_length[LEN_KEEP_W-1:0];
              addr_hi_tbl[write_ptr] = (in_mon.entry_addr_high != '0);
              addr_tbl[write_ptr] = in_mon.entry_addr_low;
              write_ptr = write_ptr + ENTRIES_W'(1);
            end
          end
          ACT_LOOKUP: begin
            expected_translations.push_back(predict_translation(in_mon.logical_block));
          end
          default: begin
          end
        endcase
      end
    end
    pending <= expected_translations.size();
    fail_count <= mismatches;
  end

endmodule

### dv/extent_block_map_lookup_tb.sv
module extent_block_map_lookup_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ebml_pkg::*;

  localparam int CAP = NODE_CAPACITY_DEF;
  localparam int RANDOM_ITEMS = 1200;
  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;

  ebml_in_if  in_ch ();
  ebml_out_if out_ch ();

  extent_block_map_lookup #(.NODE_CAPACITY(CAP)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  extent_lookup_checker #(.NODE_CAPACITY(CAP)) lookup_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  int idle_pct = 0;
  int stall_pct = 0;
  int items_sent = 0;

  // stimulus-side view of the node, only used to aim lookups and keep
  // scans inside the written part of the table
  bit          hdr_ok = 1'b0;
  int          hdr_depth = 0;
  int          hdr_count = 0;
  int          wslot = 0;
  int          written_top = 0;
  logic [31:0] aim_first [CAP];
  int          aim_len [CAP];

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic drive_transfer(input logic [ACTION_W-1:0] act, input logic [15:0] magic,
                                input logic [9:0] cnt, input logic [15:0] depth,
                                input logic [31:0] first, input logic [15:0] len_raw,
                                input logic [15:0] ahi, input logic [31:0] alo,
                                input logic [31:0] lb);
    if ($urandom_range(99) < idle_pct) begin
      in_ch.valid = 1'b0;
      do @(negedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_ch.action = act;
    in_ch.node_magic = magic;
    in_ch.node_entries = cnt;
    in_ch.node_depth = depth;
    in_ch.entry_first_block = first;
    in_ch.entry_length = len_raw;
    in_ch.entry_addr_high = ahi;
    in_ch.entry_addr_low = alo;
    in_ch.logical_block = lb;
    in_ch.valid = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    if (act != ACT_UNUSED) items_sent++;
  endtask

  task automatic send_header(input logic [15:0] magic, input logic [9:0] cnt,
                             input logic [15:0] depth);
    drive_transfer(ACT_LOAD_HDR, magic, cnt, depth, $urandom, 16'($urandom),
                   16'($urandom), $urandom, $urandom);
    hdr_ok = (magic == EXTENT_MAGIC);
    hdr_depth = int'(depth);
    hdr_count = (int'(cnt) > CAP) ? CAP : int'(cnt);
    wslot = 0;
  endtask

  task automatic send_entry(input logic [31:0] first, input logic [15:0] len_raw,
                            input logic [15:0] ahi, input logic [31:0] alo);
    drive_transfer(ACT_LOAD_ENTRY, 16'($urandom), 10'($urandom), 16'($urandom), first,
                   len_raw, ahi, alo, $urandom);
    if (wslot < CAP) begin
      aim_first[wslot] = first;
      aim_len[wslot] = int'(len_raw[LEN_KEEP_W-1:0]);
      wslot++;
      if (wslot > written_top) written_top = wslot;
    end
  endtask

  task automatic send_lookup(input logic [31:0] lb);
    // a scan must never reach a slot that was never written
    if (hdr_ok && hdr_depth <= 1 && hdr_count > written_top) return;
    drive_transfer(ACT_LOOKUP, 16'($urandom), 10'($urandom), 16'($urandom), $urandom,
                   16'($urandom), 16'($urandom), $urandom, lb);
  endtask

  task automatic query_node(input int k);
    int sel;
    int i;
    logic [31:0] lb;
    repeat (k) begin
      sel = $urandom_range(99);
      i = (hdr_count > 0) ? $urandom_range(hdr_count - 1) : 0;
      if (hdr_count > 0 && sel < 55) lb = aim_first[i] + $urandom_range(aim_len[i]);
      else if (hdr_count > 0 && sel < 65) lb = aim_first[i] - 32'd1;
      else if (sel < 80) lb = $urandom;
      else if (sel < 90) lb = '0;
      else lb = '1;
      send_lookup(lb);
    end
  endtask

  task automatic load_node(input logic [15:0] magic, input logic [15:0] depth,
                           input int n_hdr, input int n_written);
    logic [31:0] next_first;
    logic [31:0] first;
    logic [15:0] len_raw;
    int sel;
    int i;
    sel = $urandom_range(9);
    if (sel == 0) next_first = $urandom;
    else if (sel == 1) next_first = 32'hFFFF_0000 | $urandom_range(65535);
    else next_first = $urandom_range(100000);
    send_header(magic, 10'(n_hdr), depth);
    for (i = 0; i < n_written; i++) begin
      len_raw = 16'($urandom);
      if ($urandom_range(1) == 0) len_raw[14:0] = 15'($urandom_range(64));
      first = ($urandom_range(9) == 0) ? $urandom : next_first;
      if (depth == 0) next_first = first + len_raw[14:0] + $urandom_range(3);
      else next_first = first + $urandom_range(2000);
      send_entry(first, len_raw, ($urandom_range(9) == 0) ? 16'($urandom) : 16'h0,
                 $urandom);
    end
  endtask

  initial begin
    int n;
    int n_written;
    int sel;
    int full_at;
    bit full_done;
    logic [15:0] magic;

    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.action = '0;
    in_ch.node_magic = '0;
    in_ch.node_entries = '0;
    in_ch.node_depth = '0;
    in_ch.entry_first_block = '0;
    in_ch.entry_length = '0;
    in_ch.entry_addr_high = '0;
    in_ch.entry_addr_low = '0;
    in_ch.logical_block = '0;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    // directed: status codes, wrap cases, saturation, ignored action
    send_lookup(32'd5);
    send_header(16'hF30B, 10'd5, 16'd0);
    send_lookup(32'd0);
    send_header(EXTENT_MAGIC, 10'd0, 16'd2);
    send_lookup(32'd7);
    send_header(EXTENT_MAGIC, 10'd1023, 16'hFFFF);
    send_lookup(32'hFFFF_FFFF);
    send_header(EXTENT_MAGIC, 10'd0, 16'd0);
    send_lookup(32'hFFFF_FFFF);
    send_header(EXTENT_MAGIC, 10'd3, 16'd0);
    send_entry(32'hFFFF_FFF0, 16'hFFFF, 16'h0, 32'hFFFF_FFFF);
    send_entry(32'd100, 16'h8005, 16'h8000, 32'd1234);
    send_entry(32'd0, 16'h0, 16'h0, 32'd0);
    send_lookup(32'hFFFF_FFFF);
    send_lookup(32'd102);
    send_lookup(32'd0);
    drive_transfer(ACT_UNUSED, '1, '1, '1, '1, '1, '1, '1, '1);
    send_header(EXTENT_MAGIC, 10'd3, 16'd1);
    send_entry(32'd0, 16'h7FFF, 16'h0, 32'hAAAA_5555);
    send_entry(32'd1000, 16'h0, 16'hFFFF, 32'd77);
    send_entry(32'd1000, 16'h0, 16'h0, 32'hFFFF_FFFF);
    send_lookup(32'd999);
    send_lookup(32'd1000);
    send_header(EXTENT_MAGIC, 10'd1, 16'd1);
    send_entry(32'd50, 16'h0, 16'h0, 32'd9);
    send_lookup(32'd10);

    items_sent = 0;
    full_done = 1'b0;
    full_at = $urandom_range(100, 500);
    while (items_sent < RANDOM_ITEMS) begin
      case ((items_sent * 4) / RANDOM_ITEMS)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 54; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 54; end
        default: begin idle_pct = 21; stall_pct = 21; end
      endcase
      sel = $urandom_range(99);
      if (!full_done && items_sent >= full_at) begin
        // full table: count saturates and the last entries are dropped
        load_node(EXTENT_MAGIC, 16'($urandom_range(1)), $urandom_range(CAP, 1023), CAP + 8);
        query_node(10);
        full_done = 1'b1;
      end else if (sel < 70) begin
        n = ($urandom_range(9) == 0) ? $urandom_range(25, 80) : $urandom_range(1, 24);
        if ($urandom_range(19) == 0) n = 0;
        n_written = n;
        if ($urandom_range(4) == 0) n_written = n + $urandom_range(6) - 3;
        if (n_written < 0) n_written = 0;
        load_node(EXTENT_MAGIC, 16'($urandom_range(1)), n, n_written);
        query_node($urandom_range(1, 6));
      end else if (sel < 85) begin
        case ($urandom_range(3))
          0: send_header(($urandom_range(1) == 0) ? EXTENT_MAGIC : 16'($urandom),
                         10'($urandom),
                         ($urandom_range(1) == 0) ? 16'($urandom_range(3)) : 16'($urandom));
          1: send_entry($urandom, 16'($urandom), 16'($urandom), $urandom);
          2: send_lookup($urandom);
          default: drive_transfer(ACT_UNUSED, 16'($urandom), 10'($urandom), 16'($urandom),
                                  $urandom, 16'($urandom), 16'($urandom), $urandom,
                                  $urandom);
        endcase
      end else begin
        n = $urandom_range(0, 12);
        case ($urandom_range(2))
          0: begin
            magic = 16'($urandom);
            if (magic == EXTENT_MAGIC) magic[0] = ~magic[0];
            load_node(magic, 16'($urandom_range(1)), n, n);
          end
          1: load_node(EXTENT_MAGIC, ($urandom_range(3) == 0) ? 16'hFFFF :
                       16'($urandom_range(2, 65535)), n, n);
          default: load_node(EXTENT_MAGIC, 16'($urandom_range(1)), n + $urandom_range(1, 8),
                             n);
        endcase
        query_node($urandom_range(1, 3));
      end
    end

    in_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (600) @(negedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #(40_000_000);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

### files.f
rtl/ebml_pkg.sv
rtl/ebml_in_if.sv
rtl/ebml_out_if.sv
rtl/ebml_ram.sv
rtl/ebml_ctrl.sv
rtl/ebml_dp.sv
rtl/extent_block_map_lookup.sv
rtl/ebml_checker.sv
dv/extent_lookup_checker.sv
dv/extent_block_map_lookup_tb.sv
